/* src/gaps_pkg.sv */
// shared types, constants and a helper function for the grid path search block
// no dependencies; used by grid_astar_path_search
package gaps_pkg;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int IDX_W  = COL_W + ROW_W;
    localparam int NCELLS = 1 << IDX_W;
    localparam int CNT_W  = IDX_W + 1;
    localparam int COST_W = 19;
    localparam int HEUR_W = 13;
    localparam int F_W    = 20;
    localparam int PRED_W = IDX_W + 1;
    localparam int REG_W  = 7;
    localparam int GRID_COLS = 1 << COL_W;
    localparam int GRID_ROWS = 1 << ROW_W;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_IMPERFECT = 2'd2;

    localparam logic [COST_W-1:0] STEP_STRAIGHT = COST_W'(100);
    localparam logic [COST_W-1:0] STEP_DIAG     = COST_W'(114);

    typedef struct packed {
        logic [1:0]       func;
        logic [COL_W-1:0] cell_x;
        logic [ROW_W-1:0] cell_y;
        logic             wall;
        logic             seen;
        logic [COL_W-1:0] goal_x;
        logic [ROW_W-1:0] goal_y;
    } req_t;

    typedef struct packed {
        logic              reached;
        logic              has_prev;
        logic [COL_W-1:0]  prev_x;
        logic [ROW_W-1:0]  prev_y;
        logic [COST_W-1:0] path_cost;
    } rsp_t;

    typedef struct packed {
        logic              blocked;
        logic              is_open;
        logic              is_closed;
        logic [PRED_W-1:0] pred;
        logic [COST_W-1:0] cost;
        logic [HEUR_W-1:0] heur;
    } cell_t;

    // heap key: f then cell index, lower wins
    typedef struct packed {
        logic [F_W-1:0]   f;
        logic [IDX_W-1:0] idx;
    } heap_t;

    localparam int CELL_W = $bits(cell_t);
    localparam int HEAP_W = $bits(heap_t);

    function automatic logic [HEUR_W-1:0] octile(
        input logic [COL_W-1:0] x,
        input logic [ROW_W-1:0] y,
        input logic [COL_W-1:0] gx,
        input logic [ROW_W-1:0] gy
    );
        logic [COL_W-1:0] dx;
        logic [COL_W-1:0] dy;
        logic [COL_W-1:0] mn;
        logic [COL_W-1:0] mx;
        dx = (x > gx) ? x - gx : gx - x;
        dy = (y > gy) ? y - gy : gy - y;
        mn = (dx < dy) ? dx : dy;
        mx = (dx < dy) ? dy : dx;
        return HEUR_W'(HEUR_W'(mn) * HEUR_W'(114)) + HEUR_W'(HEUR_W'(mx - mn) * HEUR_W'(100));
    endfunction

endpackage

/* src/grid_astar_path_search.sv */
// top level of the grid a* path search: control sequencer, config registers
// depends on gaps_pkg and gaps_ram (cell memory and open heap memory)
//
// channel   direction  handshake            payload
// req       into       req_valid/req_stall  gaps_pkg::req_t
// rsp       out of     rsp_valid/rsp_stall  gaps_pkg::rsp_t
// cfg       into       cfg_we               cfg_index, cfg_data
//
// load and query: a cell read, then a modify/write or result, then output
// search: the time per expanded cell is set by the single read port
//   of the cell memory (three reads per neighbour) and the heap sift loops
// after reset a clearing pass over all 4096 cells zeroes the cell memory; no
//   transaction is accepted on req meanwhile
// a finished result sits in the output register while the next req is taken
module grid_astar_path_search (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  gaps_pkg::req_t                          req,
    output logic                                    rsp_valid,
    input  logic                                    rsp_stall,
    output gaps_pkg::rsp_t                          rsp,
    input  logic                                    cfg_we,
    input  logic [1:0]                              cfg_index,
    input  logic [gaps_pkg::REG_W-1:0]              cfg_data
);

    // sequencer states
    localparam logic [4:0] ST_CLR     = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_LD_WR   = 5'd2;
    localparam logic [4:0] ST_QRY     = 5'd3;
    localparam logic [4:0] ST_SR_INIT = 5'd4;
    localparam logic [4:0] ST_POP     = 5'd5;
    localparam logic [4:0] ST_POP_TOP = 5'd6;
    localparam logic [4:0] ST_POP_LST = 5'd7;
    localparam logic [4:0] ST_SD_L    = 5'd8;
    localparam logic [4:0] ST_SD_R    = 5'd9;
    localparam logic [4:0] ST_SD_CMP  = 5'd10;
    localparam logic [4:0] ST_NODE_RD = 5'd11;
    localparam logic [4:0] ST_NODE_WR = 5'd12;
    localparam logic [4:0] ST_NB      = 5'd13;
    localparam logic [4:0] ST_NB_B    = 5'd14;
    localparam logic [4:0] ST_NB_C    = 5'd15;
    localparam logic [4:0] ST_NB_D    = 5'd16;
    localparam logic [4:0] ST_SU      = 5'd17;
    localparam logic [4:0] ST_SU_CK   = 5'd18;
    localparam logic [4:0] ST_SCAN    = 5'd19;
    localparam logic [4:0] ST_SCAN_CK = 5'd20;
    localparam logic [4:0] ST_ADV     = 5'd21;
    localparam logic [4:0] ST_GOAL    = 5'd22;
    localparam logic [4:0] ST_OUT     = 5'd23;

    localparam int IW = gaps_pkg::IDX_W;
    localparam int CW = gaps_pkg::COL_W;
    localparam int RW = gaps_pkg::ROW_W;
    localparam int NW = gaps_pkg::CNT_W;

    // memory ports
    logic                     cell_we;
    logic [IW-1:0]            cell_waddr;
    gaps_pkg::cell_t          cell_wdata;
    logic [IW-1:0]            cell_raddr;
    gaps_pkg::cell_t          cell_rdata;
    logic                     heap_we;
    logic [IW-1:0]            heap_waddr;
    gaps_pkg::heap_t          heap_wdata;
    logic [IW-1:0]            heap_raddr;
    gaps_pkg::heap_t          heap_rdata;

    // control registers
    logic [4:0]               state_reg, state_next;
    logic [IW:0]              clr_reg, clr_next;
    logic [NW-1:0]            count_reg, count_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [gaps_pkg::REG_W-1:0] width_reg, height_reg;
    logic                     imperfect_reg;

    // datapath registers
    gaps_pkg::req_t           item_reg, item_next;
    gaps_pkg::rsp_t           res_reg, res_next;
    gaps_pkg::rsp_t           rsp_reg, rsp_next;
    logic [IW-1:0]            start_reg, start_next;
    logic [IW-1:0]            node_reg, node_next;
    logic [gaps_pkg::COST_W-1:0] ncost_reg, ncost_next;
    gaps_pkg::heap_t          top_reg, top_next;
    gaps_pkg::heap_t          cur_reg, cur_next;
    gaps_pkg::heap_t          lv_reg, lv_next;
    logic                     rok_reg, rok_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic [NW-1:0]            scan_reg, scan_next;
    logic [1:0]               dy_reg, dy_next;
    logic [1:0]               dx_reg, dx_next;
    logic [CW-1:0]            nbx_reg, nbx_next;
    logic [RW-1:0]            nby_reg, nby_next;
    logic                     blka_reg, blka_next;
    logic                     blkb_reg, blkb_next;

    // saturated region size
    logic [gaps_pkg::REG_W-1:0] reg_w, reg_h;
    // neighbour candidate
    logic [7:0]               yy8, xx8;
    logic                     nb_skip;
    logic [NW-1:0]            lchild, rchild;
    logic [IW-1:0]            parent;
    logic [gaps_pkg::COST_W-1:0] step_g;
    logic [gaps_pkg::HEUR_W-1:0] nb_heur;
    gaps_pkg::heap_t          best_v;
    logic [IW-1:0]            best_p;
    logic                     best_cur;
    logic [IW-1:0]            qpred;

    gaps_ram #(.WIDTH(gaps_pkg::CELL_W), .DEPTH(gaps_pkg::NCELLS)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gaps_ram #(.WIDTH(gaps_pkg::HEAP_W), .DEPTH(gaps_pkg::NCELLS)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // region registers clamp to 1..grid size
    assign reg_w = (width_reg == '0) ? gaps_pkg::REG_W'(1) :
                   (width_reg > gaps_pkg::REG_W'(gaps_pkg::GRID_COLS)) ?
                   gaps_pkg::REG_W'(gaps_pkg::GRID_COLS) : width_reg;
    assign reg_h = (height_reg == '0) ? gaps_pkg::REG_W'(1) :
                   (height_reg > gaps_pkg::REG_W'(gaps_pkg::GRID_ROWS)) ?
                   gaps_pkg::REG_W'(gaps_pkg::GRID_ROWS) : height_reg;

    // neighbour offsets: dy/dx of 0,1,2 mean -1,0,+1; underflow wraps high
    assign yy8 = 8'(node_reg[IW-1:CW]) + 8'(dy_reg) - 8'd1;
    assign xx8 = 8'(node_reg[CW-1:0]) + 8'(dx_reg) - 8'd1;
    assign nb_skip = (yy8 >= 8'(reg_h)) || (xx8 >= 8'(reg_w)) ||
                     (dy_reg == 2'd1 && dx_reg == 2'd1);

    assign lchild = {pos_reg, 1'b1};
    assign rchild = {pos_reg, 1'b0} + NW'(2);
    assign parent = (pos_reg - IW'(1)) >> 1;

    assign step_g = ncost_reg + (((nbx_reg != node_reg[CW-1:0]) &&
                                  (nby_reg != node_reg[IW-1:CW])) ?
                                 gaps_pkg::STEP_DIAG : gaps_pkg::STEP_STRAIGHT);
    assign nb_heur = gaps_pkg::octile(nbx_reg, nby_reg, item_reg.goal_x, item_reg.goal_y);

    // smallest of hole value and the two children
    always_comb
    begin
        best_v   = cur_reg;
        best_p   = pos_reg;
        best_cur = 1'b1;
        if (lv_reg < best_v)
        begin
            best_v   = lv_reg;
            best_p   = lchild[IW-1:0];
            best_cur = 1'b0;
        end
        if (rok_reg && (heap_rdata < best_v))
        begin
            best_v   = heap_rdata;
            best_p   = rchild[IW-1:0];
            best_cur = 1'b0;
        end
    end

    assign qpred = cell_rdata.pred[IW-1:0] - IW'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        start_next     = start_reg;
        node_next      = node_reg;
        ncost_next     = ncost_reg;
        top_next       = top_reg;
        cur_next       = cur_reg;
        lv_next        = lv_reg;
        rok_next       = rok_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        dy_next        = dy_reg;
        dx_next        = dx_reg;
        nbx_next       = nbx_reg;
        nby_next       = nby_reg;
        blka_next      = blka_reg;
        blkb_next      = blkb_reg;

        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = cell_rdata;
        cell_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = '0;
        heap_wdata = cur_reg;
        heap_raddr = '0;

        // output register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                // zero every cell entry after reset
                cell_we    = 1'b1;
                cell_waddr = clr_reg[IW-1:0];
                cell_wdata = '0;
                clr_next   = clr_reg + (IW+1)'(1);
                if (clr_reg[IW-1:0] == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cell_raddr = {req.cell_y, req.cell_x};
                if (req_valid)
                begin
                    item_next = req;
                    res_next  = '0;
                    unique case (req.func)
                        gaps_pkg::FUNC_LOAD:   state_next = ST_LD_WR;
                        gaps_pkg::FUNC_QUERY:  state_next = ST_QRY;
                        gaps_pkg::FUNC_SEARCH:
                        begin
                            if (({1'b0, req.cell_x} >= reg_w) ||
                                ({1'b0, req.cell_y} >= reg_h) ||
                                ({1'b0, req.goal_x} >= reg_w) ||
                                ({1'b0, req.goal_y} >= reg_h))
                            begin
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                start_next = {req.cell_y, req.cell_x};
                                state_next = ST_SR_INIT;
                            end
                        end
                        default:               state_next = ST_OUT;
                    endcase
                end
            end
            ST_LD_WR:
            begin
                cell_we              = 1'b1;
                cell_waddr           = {item_reg.cell_y, item_reg.cell_x};
                cell_wdata.blocked   = imperfect_reg ? (item_reg.wall & item_reg.seen)
                                                     : item_reg.wall;
                cell_wdata.is_open   = 1'b0;
                cell_wdata.is_closed = 1'b0;
                cell_wdata.pred      = '0;
                state_next           = ST_OUT;
            end
            ST_QRY:
            begin
                if (cell_rdata.is_closed)
                begin
                    res_next.reached   = 1'b1;
                    res_next.path_cost = cell_rdata.cost;
                end
                if (cell_rdata.pred != '0)
                begin
                    res_next.has_prev = 1'b1;
                    res_next.prev_x   = qpred[CW-1:0];
                    res_next.prev_y   = qpred[IW-1:CW];
                end
                state_next = ST_OUT;
            end
            ST_SR_INIT:
            begin
                // start cell: cost 0, open, no predecessor; heap holds it alone
                cell_we              = 1'b1;
                cell_waddr           = start_reg;
                cell_wdata.is_open   = 1'b1;
                cell_wdata.is_closed = 1'b0;
                cell_wdata.pred      = '0;
                cell_wdata.cost      = '0;
                cell_wdata.heur      = gaps_pkg::octile(item_reg.cell_x, item_reg.cell_y,
                                                        item_reg.goal_x, item_reg.goal_y);
                heap_we              = 1'b1;
                heap_waddr           = '0;
                heap_wdata.f         = gaps_pkg::F_W'(cell_wdata.heur);
                heap_wdata.idx       = start_reg;
                count_next           = NW'(1);
                state_next           = ST_POP;
            end
            ST_POP:
            begin
                heap_raddr = '0;
                if (count_reg == '0)
                begin
                    cell_raddr = {item_reg.goal_y, item_reg.goal_x};
                    state_next = ST_GOAL;
                end
                else
                begin
                    state_next = ST_POP_TOP;
                end
            end
            ST_POP_TOP:
            begin
                top_next   = heap_rdata;
                heap_raddr = IW'(count_reg - NW'(1));
                count_next = count_reg - NW'(1);
                state_next = ST_POP_LST;
            end
            ST_POP_LST:
            begin
                node_next = top_reg.idx;
                if (count_reg == '0)
                begin
                    state_next = ST_NODE_RD;
                end
                else
                begin
                    cur_next   = heap_rdata;
                    pos_next   = '0;
                    state_next = ST_SD_L;
                end
            end
            ST_SD_L:
            begin
                heap_raddr = lchild[IW-1:0];
                if (lchild >= count_reg)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = pos_reg;
                    state_next = ST_NODE_RD;
                end
                else
                begin
                    state_next = ST_SD_R;
                end
            end
            ST_SD_R:
            begin
                lv_next    = heap_rdata;
                heap_raddr = rchild[IW-1:0];
                rok_next   = (rchild < count_reg);
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP:
            begin
                heap_we    = 1'b1;
                heap_waddr = pos_reg;
                heap_wdata = best_v;
                if (best_cur)
                begin
                    state_next = ST_NODE_RD;
                end
                else
                begin
                    pos_next   = best_p;
                    state_next = ST_SD_L;
                end
            end
            ST_NODE_RD:
            begin
                cell_raddr = node_reg;
                state_next = ST_NODE_WR;
            end
            ST_NODE_WR:
            begin
                ncost_next           = cell_rdata.cost;
                cell_we              = 1'b1;
                cell_waddr           = node_reg;
                cell_wdata.is_open   = 1'b0;
                cell_wdata.is_closed = 1'b1;
                dy_next              = 2'd0;
                dx_next              = 2'd0;
                state_next           = ST_NB;
            end
            ST_NB:
            begin
                nbx_next   = xx8[CW-1:0];
                nby_next   = yy8[RW-1:0];
                // corner cell in the neighbour's row, own column
                cell_raddr = {yy8[RW-1:0], node_reg[CW-1:0]};
                state_next = nb_skip ? ST_ADV : ST_NB_B;
            end
            ST_NB_B:
            begin
                blka_next  = cell_rdata.blocked;
                cell_raddr = {node_reg[IW-1:CW], nbx_reg};
                state_next = ST_NB_C;
            end
            ST_NB_C:
            begin
                blkb_next  = cell_rdata.blocked;
                cell_raddr = {nby_reg, nbx_reg};
                state_next = ST_NB_D;
            end
            ST_NB_D:
            begin
                cell_waddr = {nby_reg, nbx_reg};
                state_next = ST_ADV;
                if (!(cell_rdata.is_closed || blka_reg || blkb_reg || cell_rdata.blocked))
                begin
                    if (!cell_rdata.is_open)
                    begin
                        cell_we            = 1'b1;
                        cell_wdata.is_open = 1'b1;
                        cell_wdata.pred    = gaps_pkg::PRED_W'(node_reg) + gaps_pkg::PRED_W'(1);
                        cell_wdata.heur    = nb_heur;
                        cell_wdata.cost    = step_g;
                        if (count_reg < NW'(gaps_pkg::NCELLS))
                        begin
                            pos_next     = count_reg[IW-1:0];
                            count_next   = count_reg + NW'(1);
                            cur_next.f   = gaps_pkg::F_W'(step_g) + gaps_pkg::F_W'(nb_heur);
                            cur_next.idx = {nby_reg, nbx_reg};
                            state_next   = ST_SU;
                        end
                    end
                    else if (cell_rdata.cost > step_g)
                    begin
                        // cheaper path to an open cell: find it in the heap
                        cell_we         = 1'b1;
                        cell_wdata.pred = gaps_pkg::PRED_W'(node_reg) + gaps_pkg::PRED_W'(1);
                        cell_wdata.cost = step_g;
                        cur_next.f      = gaps_pkg::F_W'(step_g) +
                                          gaps_pkg::F_W'(cell_rdata.heur);
                        cur_next.idx    = {nby_reg, nbx_reg};
                        scan_next       = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SU:
            begin
                heap_raddr = parent;
                if (pos_reg == '0)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = '0;
                    state_next = ST_ADV;
                end
                else
                begin
                    state_next = ST_SU_CK;
                end
            end
            ST_SU_CK:
            begin
                heap_we    = 1'b1;
                heap_waddr = pos_reg;
                if (cur_reg < heap_rdata)
                begin
                    heap_wdata = heap_rdata;
                    pos_next   = parent;
                    state_next = ST_SU;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            ST_SCAN:
            begin
                heap_raddr = scan_reg[IW-1:0];
                state_next = (scan_reg < count_reg) ? ST_SCAN_CK : ST_ADV;
            end
            ST_SCAN_CK:
            begin
                if (heap_rdata.idx == cur_reg.idx)
                begin
                    pos_next   = scan_reg[IW-1:0];
                    state_next = ST_SU;
                end
                else
                begin
                    scan_next  = scan_reg + NW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_ADV:
            begin
                if (dx_reg == 2'd2)
                begin
                    dx_next = 2'd0;
                    if (dy_reg == 2'd2)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        dy_next    = dy_reg + 2'd1;
                        state_next = ST_NB;
                    end
                end
                else
                begin
                    dx_next    = dx_reg + 2'd1;
                    state_next = ST_NB;
                end
            end
            ST_GOAL:
            begin
                if (start_reg == {item_reg.goal_y, item_reg.goal_x})
                begin
                    res_next.reached = 1'b1;
                end
                else if (cell_rdata.pred != '0)
                begin
                    res_next.reached   = 1'b1;
                    res_next.path_cost = cell_rdata.cost;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to be free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= gaps_pkg::REG_W'(gaps_pkg::GRID_COLS);
            height_reg    <= gaps_pkg::REG_W'(gaps_pkg::GRID_ROWS);
            imperfect_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gaps_pkg::CFG_WIDTH:     width_reg     <= cfg_data;
                    gaps_pkg::CFG_HEIGHT:    height_reg    <= cfg_data;
                    gaps_pkg::CFG_IMPERFECT: imperfect_reg <= cfg_data[0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        item_reg  <= item_next;
        res_reg   <= res_next;
        start_reg <= start_next;
        node_reg  <= node_next;
        ncost_reg <= ncost_next;
        top_reg   <= top_next;
        cur_reg   <= cur_next;
        lv_reg    <= lv_next;
        rok_reg   <= rok_next;
        pos_reg   <= pos_next;
        scan_reg  <= scan_next;
        dy_reg    <= dy_next;
        dx_reg    <= dx_next;
        nbx_reg   <= nbx_next;
        nby_reg   <= nby_next;
        blka_reg  <= blka_next;
        blkb_reg  <= blkb_next;
    end

endmodule

/* src/gaps_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
